>>> rtl/core/g2c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package g2c_pkg;

    localparam int CORDIC_STAGES = 32;
    localparam int NEWTON_STEPS  = 6;
    localparam int MUL_LAT       = 3;
    // six standalone multiplies plus three per newton step, the cordic row, the output register
    localparam int PIPE_LATENCY  = MUL_LAT * (6 + 3 * NEWTON_STEPS) + CORDIC_STAGES + 1;

    localparam logic signed [63:0] Q60_ONE   = 64'sh1000_0000_0000_0000;
    localparam logic signed [63:0] THREE_Q60 = 64'sh3000_0000_0000_0000;
    localparam logic signed [63:0] PI_Q60    = 64'sh3243_F6A8_885A_308D;

    // rescale shifts of the product unit
    localparam logic [5:0] SH_ANGLE  = 6'd31;
    localparam logic [5:0] SH_Q60    = 6'd60;
    localparam logic [5:0] SH_NEWTON = 6'd61;
    localparam logic [5:0] SH_AXIS   = 6'd44;

    // configuration register indexes
    localparam logic REG_AXIS = 1'b0;
    localparam logic REG_FLAT = 1'b1;

    typedef struct packed {
        logic               vld;
        logic [1:0]         q_lat;
        logic [1:0]         q_lon;
        logic signed [63:0] hq;
        logic signed [63:0] sp;
        logic signed [63:0] cp;
        logic signed [63:0] sl;
        logic signed [63:0] cl;
        logic signed [63:0] w;
        logic signed [63:0] yr;
        logic signed [63:0] ne;
    } side_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } rot_t;

    // taylor series of atan(2^-i), each term truncated
    function automatic logic [63:0] atan_q60(input int i);
        logic [63:0] sum;
        int          e;
        sum = '0;
        for (int k = 0; k < 32; k++)
        begin
            e = 60 - i * (2 * k + 1);
            if (e >= 0)
            begin
                if ((k & 1) != 0)
                    sum = sum - (64'd1 << e) / 64'(2 * k + 1);
                else
                    sum = sum + (64'd1 << e) / 64'(2 * k + 1);
            end
        end
        return sum;
    endfunction

    // product of (1 + 4^-i)^(-1/2) over the stages
    function automatic logic [63:0] gain_q60_calc();
        logic [63:0]  gain;
        logic [63:0]  f;
        logic [63:0]  t;
        logic [127:0] prod;
        int           sh;
        logic         stop;
        gain = Q60_ONE;
        for (int i = 1; i <= CORDIC_STAGES; i++)
        begin
            f    = Q60_ONE;
            t    = Q60_ONE;
            sh   = 2 * i;
            stop = 1'b0;
            for (int k = 1; k < 48; k++)
            begin
                if (!stop)
                begin
                    t = (sh >= 64) ? 64'd0 : (t >> sh);
                    t = t * 64'(2 * k - 1) / 64'(2 * k);
                    if (t == 64'd0)
                        stop = 1'b1;
                    else if ((k & 1) != 0)
                        f = f - t;
                    else
                        f = f + t;
                end
            end
            prod = {64'd0, gain} * {64'd0, f};
            prod = prod + (128'd1 << 59);
            gain = prod[123:60];
        end
        return gain;
    endfunction

    localparam logic signed [63:0] GAIN_Q60 = gain_q60_calc();

endpackage

`default_nettype wire

>>> rtl/core/g2c_mulq.sv
`timescale 1ns / 1ps
`default_nettype none

// round(a * b / 2^shift) half away from zero, saturated, three stages
module g2c_mulq
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic signed [63:0] a,
    input  wire logic signed [63:0] b,
    input  wire logic [5:0]         shift,
    input  wire g2c_pkg::side_t     side_in,
    output logic signed [63:0]      p,
    output g2c_pkg::side_t          side_out
);

    logic [63:0]    ua_reg, ub_reg;
    logic           neg1_reg, neg2_reg;
    g2c_pkg::side_t side1_reg, side2_reg, side3_reg;
    logic [63:0]    pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [63:0]    p_reg, p_next;
    logic [127:0]   sum_w, quo_w;
    logic [63:0]    mag_w;

    always_comb
    begin
        sum_w = {64'd0, pp00_reg} + {32'd0, pp01_reg, 32'd0} + {32'd0, pp10_reg, 32'd0}
              + {pp11_reg, 64'd0} + (128'd1 << (shift - 6'd1));
        quo_w = sum_w >> shift;
        mag_w = (|quo_w[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : quo_w[63:0];
        p_next = neg2_reg ? (64'd0 - mag_w) : mag_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
        end
        else
        begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg   <= a[63] ? (64'd0 - a) : a;
        ub_reg   <= b[63] ? (64'd0 - b) : b;
        neg1_reg <= a[63] ^ b[63];
        pp00_reg <= ua_reg[31:0]  * ub_reg[31:0];
        pp01_reg <= ua_reg[31:0]  * ub_reg[63:32];
        pp10_reg <= ua_reg[63:32] * ub_reg[31:0];
        pp11_reg <= ua_reg[63:32] * ub_reg[63:32];
        neg2_reg <= neg1_reg;
        p_reg    <= p_next;
    end

    assign p        = p_reg;
    assign side_out = side3_reg;

endmodule

`default_nettype wire

>>> rtl/core/g2c_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// one micro-rotation for the latitude and the longitude vector
module g2c_cordic_cell
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [5:0]         shift,
    input  wire logic signed [63:0] atan_val,
    input  wire g2c_pkg::rot_t      lat_in,
    input  wire g2c_pkg::rot_t      lon_in,
    input  wire g2c_pkg::side_t     side_in,
    output g2c_pkg::rot_t           lat_out,
    output g2c_pkg::rot_t           lon_out,
    output g2c_pkg::side_t          side_out
);

    g2c_pkg::rot_t  lat_reg, lat_next, lon_reg, lon_next;
    g2c_pkg::side_t side_reg;

    function automatic g2c_pkg::rot_t rotate(input g2c_pkg::rot_t v, input logic [5:0] sh,
                                             input logic signed [63:0] ang);
        g2c_pkg::rot_t r;
        if (!v.z[63])
        begin
            r.x = v.x - (v.y >>> sh);
            r.y = v.y + (v.x >>> sh);
            r.z = v.z - ang;
        end
        else
        begin
            r.x = v.x + (v.y >>> sh);
            r.y = v.y - (v.x >>> sh);
            r.z = v.z + ang;
        end
        return r;
    endfunction

    always_comb
    begin
        lat_next = rotate(lat_in, shift, atan_val);
        lon_next = rotate(lon_in, shift, atan_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        lat_reg <= lat_next;
        lon_reg <= lon_next;
    end

    assign lat_out  = lat_reg;
    assign lon_out  = lon_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

>>> rtl/core/g2c_newton_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// one newton step toward 1/sqrt(w): yr = yr * (3 - w * yr^2) / 2
module g2c_newton_cell
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire g2c_pkg::side_t side_in,
    output g2c_pkg::side_t      side_out
);

    logic signed [63:0] yy, wyy, t, yr_new;
    g2c_pkg::side_t     side_a, side_b, side_c;

    g2c_mulq u_sq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (side_in.yr),
        .b        (side_in.yr),
        .shift    (g2c_pkg::SH_Q60),
        .side_in  (side_in),
        .p        (yy),
        .side_out (side_a)
    );

    g2c_mulq u_wyy
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (side_a.w),
        .b        (yy),
        .shift    (g2c_pkg::SH_Q60),
        .side_in  (side_a),
        .p        (wyy),
        .side_out (side_b)
    );

    assign t = g2c_pkg::THREE_Q60 - wyy;

    g2c_mulq u_upd
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (side_b.yr),
        .b        (t),
        .shift    (g2c_pkg::SH_NEWTON),
        .side_in  (side_b),
        .p        (yr_new),
        .side_out (side_c)
    );

    always_comb
    begin
        side_out    = side_c;
        side_out.yr = yr_new;
    end

endmodule

`default_nettype wire

>>> rtl/core/geodetic_to_cartesian_core.sv
// geodetic to ecef converter, fully pipelined: one item per clock, no stall
// path: from the start edge to the done strobe an item passes 24 three-stage multipliers,
//   32 cordic cells and one output register; the receiver cannot stall, busy stays low
// reset: rst_n asynchronous active low, clears the pipeline valid bits and loads wgs-84
`timescale 1ns / 1ps
`default_nettype none

module geodetic_to_cartesian_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] latitude_angle,
    input  wire logic signed [31:0] longitude_angle,
    input  wire logic signed [27:0] height_mm,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_index,
    input  wire logic [44:0]        cfg_data,
    output logic                    done,
    output logic signed [34:0]      x_mm,
    output logic signed [34:0]      y_mm,
    output logic signed [34:0]      z_mm
);

    // configuration
    logic [32:0] axis_reg;
    logic [44:0] flat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= 33'd6378137000;
            flat_reg <= 45'd943732303377;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                g2c_pkg::REG_AXIS: axis_reg <= cfg_data[32:0];
                g2c_pkg::REG_FLAT: flat_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // e2 = 2f - f^2, recomputed every cycle; settles long before an item needs it
    logic signed [63:0] f60, ff, e2_reg, ome2_reg;
    assign f60 = {7'd0, flat_reg, 12'd0};

    g2c_mulq u_ff
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (f60),
        .b        (f60),
        .shift    (g2c_pkg::SH_Q60),
        .side_in  ('0),
        .p        (ff),
        .side_out ()
    );

    always_ff @(posedge clk)
    begin
        e2_reg   <= {f60[62:0], 1'b0} - ff;
        ome2_reg <= g2c_pkg::Q60_ONE - ({f60[62:0], 1'b0} - ff);
    end

    // accept: the pipeline never stalls
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // quadrant reduction, residual in [-2^29, 2^29)
    logic [32:0]        lat_sum, lon_sum;
    logic [1:0]         q_lat, q_lon;
    logic [31:0]        r_lat, r_lon;
    g2c_pkg::side_t     in_side;

    always_comb
    begin
        lat_sum = {1'b0, latitude_angle} + 33'h0_2000_0000;
        lon_sum = {1'b0, longitude_angle} + 33'h0_2000_0000;
        q_lat   = lat_sum[31:30];
        q_lon   = lon_sum[31:30];
        r_lat   = latitude_angle - {q_lat, 30'd0};
        r_lon   = longitude_angle - {q_lon, 30'd0};
        in_side       = '0;
        in_side.vld   = accept;
        in_side.q_lat = q_lat;
        in_side.q_lon = q_lon;
        in_side.hq    = {{20{height_mm[27]}}, height_mm, 16'd0};
    end

    // residual angle to q60 radians
    logic signed [63:0] z_lat, z_lon;
    g2c_pkg::side_t     cord_side [0:g2c_pkg::CORDIC_STAGES];
    g2c_pkg::rot_t      lat_rot [0:g2c_pkg::CORDIC_STAGES];
    g2c_pkg::rot_t      lon_rot [0:g2c_pkg::CORDIC_STAGES];

    g2c_mulq u_zlat
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        ({{32{r_lat[31]}}, r_lat}),
        .b        (g2c_pkg::PI_Q60),
        .shift    (g2c_pkg::SH_ANGLE),
        .side_in  (in_side),
        .p        (z_lat),
        .side_out (cord_side[0])
    );

    g2c_mulq u_zlon
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        ({{32{r_lon[31]}}, r_lon}),
        .b        (g2c_pkg::PI_Q60),
        .shift    (g2c_pkg::SH_ANGLE),
        .side_in  ('0),
        .p        (z_lon),
        .side_out ()
    );

    assign lat_rot[0] = '{x: g2c_pkg::GAIN_Q60, y: 64'sd0, z: z_lat};
    assign lon_rot[0] = '{x: g2c_pkg::GAIN_Q60, y: 64'sd0, z: z_lon};

    // row of cordic cells, stage i shifts by i
    for (genvar i = 1; i <= g2c_pkg::CORDIC_STAGES; i++)
    begin : g_cordic
        localparam logic signed [63:0] AtanI = g2c_pkg::atan_q60(i);
        g2c_cordic_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (6'(i)),
            .atan_val (AtanI),
            .lat_in   (lat_rot[i-1]),
            .lon_in   (lon_rot[i-1]),
            .side_in  (cord_side[i-1]),
            .lat_out  (lat_rot[i]),
            .lon_out  (lon_rot[i]),
            .side_out (cord_side[i])
        );
    end

    // quadrant fold back into sin and cos
    g2c_pkg::side_t sc_side;
    logic signed [63:0] lx, ly, ox, oy;

    always_comb
    begin
        lx = lat_rot[g2c_pkg::CORDIC_STAGES].x;
        ly = lat_rot[g2c_pkg::CORDIC_STAGES].y;
        ox = lon_rot[g2c_pkg::CORDIC_STAGES].x;
        oy = lon_rot[g2c_pkg::CORDIC_STAGES].y;
        sc_side = cord_side[g2c_pkg::CORDIC_STAGES];
        case (sc_side.q_lat)
            2'd0:    begin sc_side.cp = lx;       sc_side.sp = ly;       end
            2'd1:    begin sc_side.cp = -ly;      sc_side.sp = lx;       end
            2'd2:    begin sc_side.cp = -lx;      sc_side.sp = -ly;      end
            default: begin sc_side.cp = ly;       sc_side.sp = -lx;      end
        endcase
        case (sc_side.q_lon)
            2'd0:    begin sc_side.cl = ox;       sc_side.sl = oy;       end
            2'd1:    begin sc_side.cl = -oy;      sc_side.sl = ox;       end
            2'd2:    begin sc_side.cl = -ox;      sc_side.sl = -oy;      end
            default: begin sc_side.cl = oy;       sc_side.sl = -ox;      end
        endcase
    end

    // w = 1 - e2 sin^2 lat
    logic signed [63:0] sp2, e2sp2;
    g2c_pkg::side_t     sq_side, w_side_raw, w_side;

    g2c_mulq u_sp2
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (sc_side.sp),
        .b        (sc_side.sp),
        .shift    (g2c_pkg::SH_Q60),
        .side_in  (sc_side),
        .p        (sp2),
        .side_out (sq_side)
    );

    g2c_mulq u_e2sp2
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (e2_reg),
        .b        (sp2),
        .shift    (g2c_pkg::SH_Q60),
        .side_in  (sq_side),
        .p        (e2sp2),
        .side_out (w_side_raw)
    );

    always_comb
    begin
        w_side    = w_side_raw;
        w_side.w  = g2c_pkg::Q60_ONE - e2sp2;
        w_side.yr = g2c_pkg::Q60_ONE;
    end

    // newton chain for 1/sqrt(w)
    g2c_pkg::side_t newt_side [0:g2c_pkg::NEWTON_STEPS];
    assign newt_side[0] = w_side;

    for (genvar n = 0; n < g2c_pkg::NEWTON_STEPS; n++)
    begin : g_newton
        g2c_newton_cell u_step
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .side_in  (newt_side[n]),
            .side_out (newt_side[n+1])
        );
    end

    // ne = a / sqrt(w)
    logic signed [63:0] ne;
    g2c_pkg::side_t     ne_side_raw, ne_side;

    g2c_mulq u_ne
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        ({31'd0, axis_reg}),
        .b        (newt_side[g2c_pkg::NEWTON_STEPS].yr),
        .shift    (g2c_pkg::SH_AXIS),
        .side_in  (newt_side[g2c_pkg::NEWTON_STEPS]),
        .p        (ne),
        .side_out (ne_side_raw)
    );

    always_comb
    begin
        ne_side    = ne_side_raw;
        ne_side.ne = ne;
    end

    // (ne + h) cos lat and ne (1 - e2)
    logic signed [63:0] t_xy, t_z;
    g2c_pkg::side_t     t_side;

    g2c_mulq u_txy
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (ne_side.ne + ne_side.hq),
        .b        (ne_side.cp),
        .shift    (g2c_pkg::SH_Q60),
        .side_in  (ne_side),
        .p        (t_xy),
        .side_out (t_side)
    );

    g2c_mulq u_tz
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (ne_side.ne),
        .b        (ome2_reg),
        .shift    (g2c_pkg::SH_Q60),
        .side_in  ('0),
        .p        (t_z),
        .side_out ()
    );

    // final products in q16 mm
    logic signed [63:0] xq, yq, zq;
    g2c_pkg::side_t     fin_side;

    g2c_mulq u_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (t_xy),
        .b        (t_side.cl),
        .shift    (g2c_pkg::SH_Q60),
        .side_in  (t_side),
        .p        (xq),
        .side_out (fin_side)
    );

    g2c_mulq u_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (t_xy),
        .b        (t_side.sl),
        .shift    (g2c_pkg::SH_Q60),
        .side_in  ('0),
        .p        (yq),
        .side_out ()
    );

    g2c_mulq u_z
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (t_z + t_side.hq),
        .b        (t_side.sp),
        .shift    (g2c_pkg::SH_Q60),
        .side_in  ('0),
        .p        (zq),
        .side_out ()
    );

    // round to whole mm, half away from zero, and saturate to 35 bits
    function automatic logic [34:0] to_mm(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] m;
        logic [34:0] r;
        mag = v[63] ? (64'd0 - v) : v;
        m   = (mag + 64'd32768) >> 16;
        if (v[63])
            r = (m > 64'h4_0000_0000) ? 35'h4_0000_0000 : (35'd0 - m[34:0]);
        else
            r = (m > 64'h3_FFFF_FFFF) ? 35'h3_FFFF_FFFF : m[34:0];
        return r;
    endfunction

    logic        done_reg;
    logic [34:0] x_reg, y_reg, z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= fin_side.vld;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= to_mm(xq);
        y_reg <= to_mm(yq);
        z_reg <= to_mm(zq);
    end

    assign done = done_reg;
    assign x_mm = x_reg;
    assign y_mm = y_reg;
    assign z_mm = z_reg;

`ifndef SYNTHESIS
    // every result traces back to an accepted item a fixed latency earlier
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, g2c_pkg::PIPE_LATENCY))
        else $error("result without matching item");

    // the cordic row carries valid through unchanged
    a_cordic_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cord_side[g2c_pkg::CORDIC_STAGES].vld ==
            $past(cord_side[0].vld, g2c_pkg::CORDIC_STAGES))
        else $error("cordic row dropped or invented an item");
`endif

endmodule

`default_nettype wire

>>> tb/sv/geodetic_to_cartesian_core_test.sv
`timescale 1ns / 1ps
`default_nettype none

// expected ecef points, one per accepted geodetic item, checked in order
class ecef_scoreboard;

    typedef struct {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [34:0] z;
    } ecef_t;

    localparam int      STAGES   = 32;
    localparam longint  ONE_Q60  = 64'sh1000_0000_0000_0000;
    localparam longint  PI_FRAC  = 64'sh3243_F6A8_885A_308D;

    longint      arctan_tab [STAGES + 1];
    longint      cordic_gain;
    logic [32:0] axis_mm;
    logic [44:0] flat_q48;
    ecef_t       pending_points [$];
    int          mismatches;
    int          checked;

    function new();
        logic [63:0] sum;
        logic [63:0] f;
        logic [63:0] t;
        int          e;
        cordic_gain = ONE_Q60;
        arctan_tab[0] = 0;
        for (int i = 1; i <= STAGES; i++)
        begin
            sum = '0;
            for (int k = 0; k < 64; k++)
            begin
                e = 60 - i * (2 * k + 1);
                if (e < 0)
                    break;
                if (k & 1)
                    sum = sum - (64'd1 << e) / 64'(2 * k + 1);
                else
                    sum = sum + (64'd1 << e) / 64'(2 * k + 1);
            end
            arctan_tab[i] = longint'(sum);
            f = ONE_Q60;
            t = ONE_Q60;
            for (int k = 1; k < 64; k++)
            begin
                t = (2 * i >= 64) ? 64'd0 : (t >> (2 * i));
                t = t * 64'(2 * k - 1) / 64'(2 * k);
                if (t == 0)
                    break;
                if (k & 1)
                    f = f - t;
                else
                    f = f + t;
            end
            cordic_gain = mul_round(cordic_gain, longint'(f), 60);
        end
        axis_mm    = 33'd6378137000;
        flat_q48   = 45'd943732303377;
        mismatches = 0;
        checked    = 0;
    endfunction

    // round(a*b / 2^s) half away from zero, magnitude saturated
    static function longint mul_round(longint a, longint b, int s);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        longint       r;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        p   = {64'd0, ua} * {64'd0, ub};
        p   = (p + (128'd1 << (s - 1))) >> s;
        if (p > 128'h7FFF_FFFF_FFFF_FFFF)
            p = 128'h7FFF_FFFF_FFFF_FFFF;
        r = longint'(p[63:0]);
        return neg ? -r : r;
    endfunction

    function void sine_cosine(logic [31:0] angle, output longint s, output longint c);
        logic [63:0] u;
        logic [1:0]  quad;
        logic [31:0] resid;
        longint      zr;
        longint      x;
        longint      y;
        longint      nx;
        u     = {32'd0, angle};
        quad  = 2'((u + 64'h2000_0000) >> 30);
        resid = angle - ({30'd0, quad} << 30);
        zr    = mul_round(longint'(signed'(resid)), PI_FRAC, 31);
        x     = cordic_gain;
        y     = 0;
        for (int i = 1; i <= STAGES; i++)
        begin
            if (zr >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                zr = zr - arctan_tab[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                zr = zr + arctan_tab[i];
            end
            x = nx;
        end
        case (quad)
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    static function logic signed [34:0] round_mm(longint v);
        logic [63:0] mag;
        longint      m;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        m   = longint'((mag + 64'd32768) >> 16);
        if (v < 0)
            m = -m;
        if (m > (64'sd1 <<< 34) - 1)
            m = (64'sd1 <<< 34) - 1;
        if (m < -(64'sd1 <<< 34))
            m = -(64'sd1 <<< 34);
        return m[34:0];
    endfunction

    function ecef_t ecef_point(logic [31:0] lat, logic [31:0] lon, logic signed [27:0] h);
        longint sp, cp, sl, cl, hq, f60, e2, w, yr, t, ne;
        ecef_t  pt;
        sine_cosine(lat, sp, cp);
        sine_cosine(lon, sl, cl);
        hq  = longint'(h) * 65536;
        f60 = longint'({19'd0, flat_q48} << 12);
        e2  = 2 * f60 - mul_round(f60, f60, 60);
        w   = ONE_Q60 - mul_round(e2, mul_round(sp, sp, 60), 60);
        yr  = ONE_Q60;
        for (int i = 0; i < 6; i++)
        begin
            t  = 3 * ONE_Q60 - mul_round(w, mul_round(yr, yr, 60), 60);
            yr = mul_round(yr, t, 61);
        end
        ne   = mul_round(longint'({31'd0, axis_mm}), yr, 44);
        t    = mul_round(ne + hq, cp, 60);
        pt.x = round_mm(mul_round(t, cl, 60));
        pt.y = round_mm(mul_round(t, sl, 60));
        t    = mul_round(ne, ONE_Q60 - e2, 60) + hq;
        pt.z = round_mm(mul_round(t, sp, 60));
        return pt;
    endfunction

    function void note_item(logic [31:0] lat, logic [31:0] lon, logic signed [27:0] h);
        pending_points.push_back(ecef_point(lat, lon, h));
    endfunction

    task report(string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_point(logic signed [34:0] x, logic signed [34:0] y, logic signed [34:0] z);
        ecef_t pt;
        checked++;
        if (pending_points.size() == 0)
        begin
            report("point with no item pending");
            return;
        end
        pt = pending_points.pop_front();
        if (x !== pt.x)
            report($sformatf("x got %0d want %0d", x, pt.x));
        if (y !== pt.y)
            report($sformatf("y got %0d want %0d", y, pt.y));
        if (z !== pt.z)
            report($sformatf("z got %0d want %0d", z, pt.z));
    endtask

endclass

module geodetic_to_cartesian_core_test;

    localparam int CYCLE_LIMIT = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] latitude_angle = '0;
    logic signed [31:0] longitude_angle = '0;
    logic signed [27:0] height_mm = '0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = g2c_pkg::REG_AXIS;
    logic [44:0]        cfg_data = '0;
    logic               done;
    logic signed [34:0] x_mm;
    logic signed [34:0] y_mm;
    logic signed [34:0] z_mm;

    ecef_scoreboard sb = new();
    int             cycles = 0;
    int             idle_pct = 0;
    int             sent = 0;

    geodetic_to_cartesian_core dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .latitude_angle  (latitude_angle),
        .longitude_angle (longitude_angle),
        .height_mm       (height_mm),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .x_mm            (x_mm),
        .y_mm            (y_mm),
        .z_mm            (z_mm)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // input side: note every item taken at an edge where start is high and busy low
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_item(latitude_angle, longitude_angle, height_mm);
    end

    // output side: a strobe cannot be held off, so every done cycle is a point
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_point(x_mm, y_mm, z_mm);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // one item: optional idle gaps, then hold start until the block takes it
    task send_point(logic signed [31:0] lat, logic signed [31:0] lon, logic signed [27:0] h);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start           <= 1'b1;
        latitude_angle  <= lat;
        longitude_angle <= lon;
        height_mm       <= h;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    // drop start once the stream is over
    task stop_stream();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every pending point, then the pipeline depth on top
    task drain();
        stop_stream();
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (g2c_pkg::PIPE_LATENCY + 8) @(posedge clk);
    endtask

    // block must be idle; the model copy follows at once
    task write_reg(logic idx, logic [44:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == g2c_pkg::REG_AXIS)
            sb.axis_mm = value[32:0];
        else
            sb.flat_q48 = value;
    endtask

    task set_ellipsoid(logic [32:0] axis, logic [44:0] flat);
        write_reg(g2c_pkg::REG_AXIS, {12'd0, axis});
        write_reg(g2c_pkg::REG_FLAT, flat);
    endtask

    // mostly legal latitudes and heights; some take the full field width
    task random_points(int count);
        logic signed [31:0] lat;
        logic signed [27:0] h;
        int                 calm;
        calm = 0;
        for (int n = 0; n < count; n++)
        begin
            if (calm == 0 && $urandom_range(15) == 0)
                calm = 20;
            if ($urandom_range(9) == 0)
                lat = $urandom;
            else
                lat = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
            if ($urandom_range(9) == 0)
                h = 28'($urandom);
            else
                h = 28'($signed($urandom_range(200000000)) - 100000000);
            if (calm > 0)
            begin
                calm--;
                begin : no_gap
                    int keep;
                    keep     = idle_pct;
                    idle_pct = 0;
                    send_point(lat, $urandom, h);
                    idle_pct = keep;
                end
            end
            else
                send_point(lat, $urandom, h);
        end
    endtask

    initial
    begin
        int phase_idle [4];
        phase_idle = '{0, 65, 0, 37};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pole, equator, wrap of latitude, quadrant edges, height extremes
        send_point(32'sh0000_0000, 32'sh0000_0000, 28'sd0);
        send_point(32'sh4000_0000, 32'sh0000_0000, 28'sd100000000);
        send_point(-32'sh4000_0000, 32'sh4000_0000, -28'sd100000000);
        send_point(32'sh7FFF_FFFF, -32'sh8000_0000, 28'sd0);
        send_point(-32'sh8000_0000, 32'sh7FFF_FFFF, 28'sh7FF_FFFF);
        send_point(32'sh2000_0000, -32'sh2000_0000, -28'sh800_0000);
        send_point(32'sh1FFF_FFFF, 32'sh6000_0000, 28'sd1);
        send_point(-32'sh2000_0001, -32'sh6000_0000, -28'sd1);
        send_point(32'sh6000_0000, 32'sh2000_0000, 28'sd12345);
        send_point(32'sh3FFF_FFFF, 32'sh5FFF_FFFF, -28'sd98765);
        send_point(32'sh0000_0001, -32'sh0000_0001, 28'sd100000000);
        send_point(-32'sh0000_0001, 32'sh0000_0001, -28'sd100000000);
        drain();

        // extremes of the ellipsoid, including a zero axis and oversized flattening
        set_ellipsoid(33'h1_FFFF_FFFF, 45'h1000_0000_0000);
        send_point(32'sh2AAA_AAAA, 32'sh1234_5678, 28'sd100000000);
        send_point(-32'sh4000_0000, 32'sh7FFF_FFFF, 28'sh7FF_FFFF);
        drain();
        set_ellipsoid(33'd0, 45'd0);
        send_point(32'sh1000_0000, 32'sh1000_0000, 28'sd5000);
        send_point(32'sh4000_0000, -32'sh8000_0000, -28'sd5000);
        drain();
        set_ellipsoid(33'd1, 45'h1FFF_FFFF_FFFF);
        send_point(32'sh3000_0000, 32'sh3000_0000, 28'sd0);
        send_point(-32'sh3000_0000, -32'sh3000_0000, 28'sd77);
        drain();

        // random phases, each under a set ellipsoid and idle rate; some phases share them
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = phase_idle[ph];
            case (ph)
                0: set_ellipsoid(33'd6378137000, 45'd943732303377);
                1: set_ellipsoid({$urandom, 1'b1},
                                 {1'b0, 12'($urandom_range(4095)), $urandom});
                2: set_ellipsoid(33'h1_FFFF_FFFF, 45'h1000_0000_0000);
                default: set_ellipsoid(33'd6378137000, 45'd943732303377);
            endcase
            random_points(250);
            idle_pct = 0;
            drain();
        end

        $display("covered %0d geodetic items over several ellipsoids and idle rates", sent);
        $display("%0d points compared, %0d field mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_points.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
